// ----- rtl/swrm_pkg.sv -----
// ============================================================================
// swrm_pkg - shared types for the sliding window row maximum block
// Compare operation codes used by the sequencer and the shared compare unit,
// and the width of the window width register.
// ============================================================================
package swrm_pkg;

    localparam int CFG_W = 7;

    typedef enum logic
    {
        CMP_GE,
        CMP_GT
    } cmp_op_t;

endpackage

// ----- rtl/sliding_window_row_maximum_top.sv -----
// ============================================================================
// sliding_window_row_maximum_top - row pass of a sliding window maximum
// Monotonic deque of (value, position) pairs; one result per cell, and on a
// row end the trailing results of the windows clipped at the row end.
// ============================================================================
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------
//  cfg       cfg_valid / cfg_ready     window_width
//  cell      cell_valid / cell_stall   cell_prob, row_end
//  result    result_valid / result_stall   window_max, row_done
//
//  A cell goes through accept, a front eviction pass that evicts aged-out
//  entries one by one, a back pop pass that pops smaller entries one by one,
//  and a push. A row end adds W - 1 trailing beats, with front evictions
//  between them. All passes share one compare unit and the deque memory ports.
//  Reset clears the deque pointers, column position and output valid; the
//  window width resets to 1. A stalled result beat holds the sequencer at
//  the next beat it would emit. cfg_ready is always high.
//
module sliding_window_row_maximum_top #(
    parameter int MAX_WINDOW = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [swrm_pkg::CFG_W-1:0] window_width,
    input  logic                       cell_valid,
    output logic                       cell_stall,
    input  logic [VALUE_BITS-1:0]      cell_prob,
    input  logic                       row_end,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [VALUE_BITS-1:0]      window_max,
    output logic                       row_done
);

    localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int POS_MOD = 2 * MAX_WINDOW;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int EW      = (CNT_W > swrm_pkg::CFG_W) ? CNT_W : swrm_pkg::CFG_W;
    localparam int CW0     = (VALUE_BITS > POS_W) ? VALUE_BITS : POS_W;
    localparam int CMP_W   = (CW0 > CNT_W) ? CW0 : CNT_W;
    localparam int DATA_W  = VALUE_BITS + POS_W;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EVICT,
        S_POP,
        S_PUSH,
        S_DRAIN
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] h,
                                                 input logic [CNT_W-1:0] c);
        logic [PTR_W:0] s;
        s = {1'b0, h} + (PTR_W + 1)'(c);
        if (s >= (PTR_W + 1)'(MAX_WINDOW))
        begin
            s = s - (PTR_W + 1)'(MAX_WINDOW);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] back_of(input logic [PTR_W-1:0] h,
                                                 input logic [CNT_W-1:0] c);
        logic [PTR_W-1:0] s;
        s = slot_of(h, c);
        return (s == '0) ? PTR_W'(MAX_WINDOW - 1) : s - 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        return (p == POS_W'(POS_MOD - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] age_of(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] f);
        logic [POS_W:0] d;
        d = {1'b0, p} - {1'b0, f};
        if (p < f)
        begin
            d = d + (POS_W + 1)'(POS_MOD);
        end
        return d[POS_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] eff_width(input logic [swrm_pkg::CFG_W-1:0] c);
        logic [EW-1:0] x;
        x = EW'(c);
        if (x == '0)
        begin
            x = EW'(1);
        end
        if (x > EW'(MAX_WINDOW))
        begin
            x = EW'(MAX_WINDOW);
        end
        return x[CNT_W-1:0];
    endfunction

    state_t                     state_reg, state_next;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [POS_W-1:0]           col_reg, col_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [VALUE_BITS-1:0]      val_reg, val_next;
    logic                       last_reg, last_next;
    logic [CNT_W-1:0]           w_reg, w_next;
    logic [CNT_W-1:0]           t_reg, t_next;
    logic [swrm_pkg::CFG_W-1:0] width_reg, width_next;
    logic                       res_valid_reg, res_valid_next;
    logic [VALUE_BITS-1:0]      res_max_reg, res_max_next;
    logic                       res_done_reg, res_done_next;

    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    logic [DATA_W-1:0]          wr_data;
    logic [PTR_W-1:0]           rd_a_addr;
    logic [PTR_W-1:0]           rd_b_addr;
    logic [DATA_W-1:0]          rd_a_data;
    logic [DATA_W-1:0]          rd_b_data;

    logic [VALUE_BITS-1:0]      front_val;
    logic [POS_W-1:0]           front_pos;
    logic [VALUE_BITS-1:0]      back_val;
    logic [VALUE_BITS-1:0]      front_out;
    logic [POS_W-1:0]           age;

    swrm_pkg::cmp_op_t          cmp_op;
    logic [CMP_W-1:0]           cmp_a;
    logic [CMP_W-1:0]           cmp_b;
    logic                       cmp_hit;
    logic                       slot_free;

    swrm_mem #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (DATA_W),
        .ADDR_W (PTR_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    swrm_cmp #(
        .WIDTH (CMP_W)
    ) u_cmp (
        .op  (cmp_op),
        .a   (cmp_a),
        .b   (cmp_b),
        .hit (cmp_hit)
    );

    assign front_val = rd_a_data[DATA_W-1:POS_W];
    assign front_pos = rd_a_data[POS_W-1:0];
    assign back_val  = rd_b_data[DATA_W-1:POS_W];
    assign front_out = (count_reg == '0) ? '0 : front_val;
    assign age       = age_of(pos_reg, front_pos);
    assign slot_free = !res_valid_reg || !result_stall;

    // value test at the back while popping, age test at the front otherwise
    always_comb
    begin
        if (state_reg == S_POP)
        begin
            cmp_op = swrm_pkg::CMP_GT;
            cmp_a  = CMP_W'(val_reg);
            cmp_b  = CMP_W'(back_val);
        end
        else
        begin
            cmp_op = swrm_pkg::CMP_GE;
            cmp_a  = CMP_W'(age);
            cmp_b  = CMP_W'(w_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        col_next       = col_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        w_next         = w_reg;
        t_next         = t_reg;
        width_next     = width_reg;
        res_valid_next = res_valid_reg;
        res_max_next   = res_max_reg;
        res_done_next  = res_done_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_of(head_reg, count_reg);
        wr_data        = {val_reg, pos_reg};

        if (cfg_valid && cfg_ready)
        begin
            width_next = window_width;
        end

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cell_valid)
                begin
                    val_next   = cell_prob;
                    last_next  = row_end;
                    w_next     = eff_width(width_reg);
                    pos_next   = col_reg;
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if ((count_reg != '0) && cmp_hit)
                begin
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if ((count_reg != '0) && cmp_hit)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    wr_en          = 1'b1;
                    count_next     = count_reg + 1'b1;
                    res_valid_next = 1'b1;
                    res_max_next   = (count_reg == '0) ? val_reg : front_val;
                    res_done_next  = last_reg && (w_reg == CNT_W'(1));
                    if (!last_reg)
                    begin
                        col_next   = pos_inc(pos_reg);
                        state_next = S_IDLE;
                    end
                    else if (w_reg == CNT_W'(1))
                    begin
                        head_next  = '0;
                        count_next = '0;
                        col_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        t_next     = CNT_W'(1);
                        pos_next   = pos_inc(pos_reg);
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if ((count_reg != '0) && cmp_hit)
                begin
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
                else if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_max_next   = front_out;
                    res_done_next  = (t_reg == w_reg - 1'b1);
                    if (t_reg == w_reg - 1'b1)
                    begin
                        // row finished: drop the deque and restart the column
                        head_next  = '0;
                        count_next = '0;
                        col_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        t_next   = t_reg + 1'b1;
                        pos_next = pos_inc(pos_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read ahead at the next pointers so data is ready in the next cycle
    assign rd_a_addr = head_next;
    assign rd_b_addr = back_of(head_next, count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            col_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            last_reg      <= 1'b0;
            w_reg         <= CNT_W'(1);
            t_reg         <= '0;
            width_reg     <= swrm_pkg::CFG_W'(1);
            res_valid_reg <= 1'b0;
            res_max_reg   <= '0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            col_reg       <= col_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            last_reg      <= last_next;
            w_reg         <= w_next;
            t_reg         <= t_next;
            width_reg     <= width_next;
            res_valid_reg <= res_valid_next;
            res_max_reg   <= res_max_next;
            res_done_reg  <= res_done_next;
        end
    end

    assign cfg_ready    = 1'b1;
    assign cell_stall   = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign window_max   = res_max_reg;
    assign row_done     = res_done_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> (count_reg < CNT_W'(MAX_WINDOW)))
        else $error("deque full at push");

    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_done_reg) |->
            ((count_reg == '0) && (head_reg == '0) && (col_reg == '0)))
        else $error("row end beat pending with deque not cleared");

    a_evict_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT) |=> ((state_reg == S_EVICT) || (state_reg == S_POP)))
        else $error("eviction pass left to wrong state");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (count_reg != '0))
        else $error("deque empty during trailing drain");

endmodule

// ----- rtl/swrm_cmp.sv -----
// ============================================================================
// swrm_cmp - shared magnitude compare unit
// One unsigned comparator, used for the age test at the deque front and for
// the value test at the deque back.
// ============================================================================
module swrm_cmp #(
    parameter int WIDTH = 16
) (
    input  swrm_pkg::cmp_op_t  op,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic               hit
);

    always_comb
    begin
        case (op)
            swrm_pkg::CMP_GE: hit = (a >= b);
            swrm_pkg::CMP_GT: hit = (a > b);
            default:          hit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/swrm_mem.sv -----
// ============================================================================
// swrm_mem - deque storage
// One write port and two registered read ports; a read of the address being
// written returns the new data.
// ============================================================================
module swrm_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 23,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_a_addr,
    output logic [DATA_W-1:0] rd_a_data,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [DATA_W-1:0] rd_b_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // bypass the write so a freshly pushed entry reads back at once
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_a_addr))
        begin
            rd_a_data <= wr_data;
        end
        else
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (wr_en && (wr_addr == rd_b_addr))
        begin
            rd_b_data <= wr_data;
        end
        else
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule
